[rtl/core/fcpa_pkg.sv]
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared types and constants of the frame cadence phase accumulator: payload
// structs of both channels, the register set and the command codes.
// ----------------------------------------------------------------------------
package fcpa_pkg;

	// Field widths
	localparam int PERIOD_W   = 24;
	localparam int WEIGHT_W   = 17;
	localparam int ADV_W      = 4;
	localparam int TS_W       = 64;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int MUL_W      = PERIOD_W + WEIGHT_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ADVANCE    = 3'd5;

	// Register reset values
	localparam logic [PERIOD_W-1:0] RST_DISPLAY_PERIOD = 24'd1093360;
	localparam logic [PERIOD_W-1:0] RST_INITIAL_PERIOD = 24'd1092267;
	localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD     = 24'd262144;
	localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD     = 24'd6553600;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT         = 17'd6554;
	localparam logic [ADV_W-1:0]    RST_MAX_ADVANCE    = 4'd2;

	// Estimate after reset: initial period clamped to the reset bounds
	localparam logic [PERIOD_W-1:0] EST_RESET = 24'd1092267;

	// Arithmetic constants
	localparam logic [TS_W-1:0]     TS_UNKNOWN  = 64'h8000_0000_0000_0000;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 24'hFF_FFFF;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
	localparam int                  WEIGHT_SH   = 16;
	localparam int                  ROUND_HALF  = 32768;
	localparam int                  DIV_TICKS   = 90;

	typedef struct packed {
		logic [CMD_W-1:0]       cmd;
		logic signed [TS_W-1:0] timestamp;
	} item_t;

	typedef struct packed {
		logic [ADV_W-1:0]    advance_count;
		logic [PERIOD_W-1:0] stream_period;
	} result_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] display_period;
		logic [PERIOD_W-1:0] initial_stream_period;
		logic [PERIOD_W-1:0] min_stream_period;
		logic [PERIOD_W-1:0] max_stream_period;
		logic [WEIGHT_W-1:0] smoothing_weight;
		logic [ADV_W-1:0]    max_advance;
	} cfg_t;

endpackage

[rtl/core/fcpa_cfg.sv]
// ----------------------------------------------------------------------------
// fcpa_cfg
// Configuration register file. Takes one write per transfer, always ready;
// indexes past the register list are dropped.
// ----------------------------------------------------------------------------
module fcpa_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output fcpa_pkg::cfg_t                  cfg
);
	import fcpa_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_period        <= RST_DISPLAY_PERIOD;
			cfg_q.initial_stream_period <= RST_INITIAL_PERIOD;
			cfg_q.min_stream_period     <= RST_MIN_PERIOD;
			cfg_q.max_stream_period     <= RST_MAX_PERIOD;
			cfg_q.smoothing_weight      <= RST_WEIGHT;
			cfg_q.max_advance           <= RST_MAX_ADVANCE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DISPLAY_PERIOD: cfg_q.display_period        <= cfg_data[PERIOD_W-1:0];
				REG_INITIAL_PERIOD: cfg_q.initial_stream_period <= cfg_data[PERIOD_W-1:0];
				REG_MIN_PERIOD:     cfg_q.min_stream_period     <= cfg_data[PERIOD_W-1:0];
				REG_MAX_PERIOD:     cfg_q.max_stream_period     <= cfg_data[PERIOD_W-1:0];
				REG_WEIGHT:         cfg_q.smoothing_weight      <= cfg_data[WEIGHT_W-1:0];
				REG_MAX_ADVANCE:    cfg_q.max_advance           <= cfg_data[ADV_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/fcpa_div.sv]
// ----------------------------------------------------------------------------
// fcpa_div
// Shared restoring divider, one quotient bit per cycle. Serves both the tick
// to millisecond conversion and the display over stream period ratio.
// ----------------------------------------------------------------------------
module fcpa_div #(
	parameter int DW = 40,
	parameter int VW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	import fcpa_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] qr_q;

	logic [VW:0]   shifted;
	logic [VW:0]   trial;
	logic          take;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign shifted = {rem_q, qr_q[DW-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign take    = shifted >= {1'b0, dvs_q};

	assign done     = done_q;
	assign quotient = qr_q;

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			qr_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? trial[VW-1:0] : shifted[VW-1:0];
			qr_q  <= {qr_q[DW-2:0], take};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still iterating");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("divider step count lost");
`endif

endmodule

[rtl/core/fcpa_core.sv]
// ----------------------------------------------------------------------------
// fcpa_core
// Sequencer and datapath: period estimator, phase accumulator, one shared
// 24x17 multiplier for the moving average and the shared divider.
// ----------------------------------------------------------------------------
module fcpa_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcpa_pkg::cfg_t    cfg,
	input  logic              item_valid,
	output logic              item_stall,
	input  fcpa_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output fcpa_pkg::result_t result
);
	import fcpa_pkg::*;

	// Divisor wide enough for the 1000/60 ms fallback at any fraction width
	localparam int VW = (FRAC_BITS + 5 > PERIOD_W) ? FRAC_BITS + 5 : PERIOD_W;
	localparam int DW = VW + FRAC_BITS;
	localparam logic [VW-1:0] DEF_PERIOD =
		VW'(((64'd1000 << FRAC_BITS) + 64'd30) / 64'd60);
	// Differences at or above this give a sample beyond 24 bits
	localparam logic [TS_W-1:0] SAT_THRESH = 64'(DIV_TICKS) << (PERIOD_W - FRAC_BITS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHECK = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_CLAMP = 9'b000001000,
		ST_MUL1  = 9'b000010000,
		ST_MUL2  = 9'b000100000,
		ST_SUM   = 9'b001000000,
		ST_PHASE = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [PERIOD_W-1:0]  est_q;
	logic [TS_W-1:0]      prev_q;
	logic                 have_prev_q;
	logic [FRAC_BITS-1:0] phase_q;
	logic                 result_valid_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [TS_W-1:0]      diff_q;
	logic [PERIOD_W-1:0]  sample_q;
	logic [MUL_W-1:0]     prod1_q;
	logic [MUL_W-1:0]     prod2_q;
	logic [ADV_W-1:0]     adv_q;
	result_t              result_q;

	logic                 accept;
	logic                 result_free;
	logic                 skip;
	logic                 sat;
	logic [WEIGHT_W-1:0]  w_eff;
	logic [WEIGHT_W-1:0]  w_rest;
	logic [PERIOD_W-1:0]  mul_a;
	logic [WEIGHT_W-1:0]  mul_b;
	logic [MUL_W-1:0]     mul_p;
	logic [MUL_W:0]       blend;
	logic [PERIOD_W-1:0]  restart_est;
	logic [VW-1:0]        stream_div;
	logic [VW-1:0]        disp_div;
	logic                 div_start;
	logic [DW-1:0]        div_dividend;
	logic [VW-1:0]        div_divisor;
	logic                 div_done;
	logic [DW-1:0]        div_quot;
	logic [DW:0]          phase_sum;
	logic [VW:0]          whole;
	logic [ADV_W-1:0]     adv_next;

	function automatic logic [PERIOD_W-1:0] clamp_period(
		input logic [PERIOD_W-1:0] v,
		input logic [PERIOD_W-1:0] lo,
		input logic [PERIOD_W-1:0] hi
	);
		logic [PERIOD_W-1:0] t;
		t = (v < lo) ? lo : v;
		t = (t > hi) ? hi : t;
		return t;
	endfunction

	// Handshake
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_free  = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Observation checks
	assign skip = (diff_q == '0) || diff_q[TS_W-1];
	assign sat  = (diff_q >= SAT_THRESH);

	// Shared multiplier: new sample by weight, then estimate by complement
	assign w_eff  = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
	assign w_rest = WEIGHT_ONE - w_eff;
	assign mul_a  = (state_q == ST_MUL1) ? sample_q : est_q;
	assign mul_b  = (state_q == ST_MUL1) ? w_eff : w_rest;
	assign mul_p  = MUL_W'(mul_a) * MUL_W'(mul_b);
	assign blend  = {1'b0, prod1_q} + {1'b0, prod2_q} + (MUL_W + 1)'(ROUND_HALF);

	assign restart_est = clamp_period(cfg.initial_stream_period,
		cfg.min_stream_period, cfg.max_stream_period);

	// Divider operands; zero periods fall back to 1000/60 ms
	assign stream_div = (est_q == '0) ? DEF_PERIOD : VW'(est_q);
	assign disp_div   = (cfg.display_period == '0) ? DEF_PERIOD : VW'(cfg.display_period);
	assign div_start  = (accept && item.cmd == CMD_REFRESH) ||
		(state_q == ST_CHECK && !skip && !sat);
	assign div_dividend = (state_q == ST_CHECK) ?
		(DW'(diff_q[30:0]) << FRAC_BITS) : {disp_div, {FRAC_BITS{1'b0}}};
	assign div_divisor  = (state_q == ST_CHECK) ? VW'(DIV_TICKS) : stream_div;

	fcpa_div #(
		.DW (DW),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Phase update: whole part limited, only the fraction carried on
	assign phase_sum = {1'b0, div_quot} + (DW + 1)'(phase_q);
	assign whole     = phase_sum[DW:FRAC_BITS];
	assign adv_next  = (whole > (VW + 1)'(cfg.max_advance)) ? cfg.max_advance : whole[ADV_W-1:0];

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			est_q          <= EST_RESET;
			prev_q         <= '0;
			have_prev_q    <= 1'b0;
			phase_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// the completion step reloads the result register itself
			if (result_valid_q && !result_stall && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.cmd)
							CMD_OBSERVE: begin
								if ($unsigned(item.timestamp) == TS_UNKNOWN) begin
									state_q <= ST_DONE;
								end else if (!have_prev_q) begin
									prev_q      <= $unsigned(item.timestamp);
									have_prev_q <= 1'b1;
									state_q     <= ST_DONE;
								end else begin
									prev_q  <= $unsigned(item.timestamp);
									state_q <= ST_CHECK;
								end
							end
							CMD_REFRESH: begin
								state_q <= ST_DIV;
							end
							CMD_RESTART: begin
								est_q       <= restart_est;
								prev_q      <= '0;
								have_prev_q <= 1'b0;
								phase_q     <= '0;
								state_q     <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (skip) begin
						state_q <= ST_DONE;
					end else if (sat) begin
						state_q <= ST_CLAMP;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= (cmd_q == CMD_REFRESH) ? ST_PHASE : ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_SUM;
				ST_SUM: begin
					est_q   <= blend[PERIOD_W+WEIGHT_SH-1:WEIGHT_SH];
					state_q <= ST_DONE;
				end
				ST_PHASE: begin
					phase_q <= phase_sum[FRAC_BITS-1:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (result_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd_q  <= item.cmd;
					adv_q  <= '0;
					diff_q <= $unsigned(item.timestamp) - prev_q;
				end
			end
			ST_CHECK: begin
				if (sat) begin
					sample_q <= PERIOD_MAX;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					sample_q <= div_quot[PERIOD_W-1:0];
				end
			end
			ST_CLAMP: sample_q <= clamp_period(sample_q, cfg.min_stream_period,
				cfg.max_stream_period);
			ST_MUL1:  prod1_q <= mul_p;
			ST_MUL2:  prod2_q <= mul_p;
			ST_PHASE: adv_q <= adv_next;
			ST_DONE: begin
				if (result_free) begin
					result_q.advance_count <= adv_q;
					result_q.stream_period <= est_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider result outside the divide step");
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == CMD_RESTART) |=> (!have_prev_q && phase_q == '0))
		else $error("restart left timestamp or phase state");
	a_est_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(est_q) |-> ($past(state_q == ST_SUM) || $past(accept)))
		else $error("estimate changed outside blend or restart");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the completion step");
`endif

endmodule

[rtl/core/frame_cadence_phase_accumulator_top.sv]
// ----------------------------------------------------------------------------
// frame_cadence_phase_accumulator_top
// Paces stream frames onto display refreshes: smoothed stream period estimate
// from 90 kHz timestamps and a fixed-point phase that yields frames to advance.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------
//   item     | in        | item_valid/item_stall  | item_t   (cmd, timestamp)
//   result   | out       | result_valid/stall     | result_t (advance, period)
//   cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One item at a time. Observe steps through check, divide, clamp, first and
// second multiply, sum and done; refresh through divide, phase and done. A
// saturating difference skips the divide; restart, unknown or first timestamps
// and command three go straight to done; skipped differences go check to done.
// The shared divider yields one quotient bit per cycle.
// Reset loads the register defaults and the clamped initial estimate at once.
// A stalled result holds the finished item; the next one is taken meanwhile.
// ----------------------------------------------------------------------------
module frame_cadence_phase_accumulator_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  fcpa_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output fcpa_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcpa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fcpa_pkg::*;

	cfg_t cfg;

	// Register file
	fcpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Estimator, phase and sequencer
	fcpa_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
